// File: hdl/pru_pkg.sv
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants for the pixel replicating upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

	localparam int DEF_MAX_WIDTH = 4096;
	localparam int DEF_MAX_SCALE = 64;

	localparam int SCALE_W    = 7;
	localparam int ROW_W      = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int PIX_W      = 24;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 1'd1;

	// Input item functions.
	localparam logic FUNC_PIXEL  = 1'b0;
	localparam logic FUNC_REPLAY = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_NO_REPLAY  = 2'd1;
	localparam logic [1:0] STATUS_REPLAY_DUE = 2'd2;

	typedef struct packed {
		logic       func;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       row_end;
		logic       last;
		logic [1:0] status;
	} pix_out_t;

endpackage

// File: hdl/pru_ram.sv
// ----------------------------------------------------------------------------
// pru_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module pru_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/pixel_replicating_upscaler.sv
// ----------------------------------------------------------------------------
// pixel_replicating_upscaler
// Each item is held in the copy emitter, which hands its copies to the output
// register. An item gives its effective scale (the register clamped to
// 1..MAX_SCALE) in copies, a refused item a single result; the emitter sends one
// copy per cycle while the output is not stalled, and at scale 1 one item per
// cycle. Reset clears the row position, replay count and registers (scale 1,
// width 1); the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module pixel_replicating_upscaler #(
	parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
	parameter int MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pru_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pru_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Source item channel.
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  pru_pkg::pix_in_t                    pix_data,
	// Result channel.
	output logic                                up_valid,
	input  logic                                up_stall,
	output pru_pkg::pix_out_t                   up_data
);

	// Widths derived from the parameters.
	localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CNT_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
	localparam int EW      = ((MW_BITS > pru_pkg::ROW_W) ? MW_BITS : pru_pkg::ROW_W) + 1;
	localparam int ES      = pru_pkg::SCALE_W + 1;

	// Configuration registers. Writes are always taken.
	logic [pru_pkg::SCALE_W-1:0] scale_factor_q;
	logic [pru_pkg::ROW_W-1:0]   row_width_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_factor_q <= pru_pkg::SCALE_W'(1);
			row_width_q    <= pru_pkg::ROW_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pru_pkg::REG_SCALE_FACTOR: scale_factor_q <= cfg_data[pru_pkg::SCALE_W-1:0];
				pru_pkg::REG_ROW_WIDTH:    row_width_q    <= cfg_data[pru_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective scale and width. A zero register acts as one, and a value
	// above the built-in maximum acts as that maximum.
	logic [ES-1:0]    eff_scale;
	logic [EW-1:0]    eff_width;
	logic [CNT_W-1:0] copies_m1;

	always_comb begin
		if (scale_factor_q == '0) begin
			eff_scale = ES'(1);
		end else if (ES'(scale_factor_q) > ES'(MAX_SCALE)) begin
			eff_scale = ES'(MAX_SCALE);
		end else begin
			eff_scale = ES'(scale_factor_q);
		end
		if (row_width_q == '0) begin
			eff_width = EW'(1);
		end else if (EW'(row_width_q) > EW'(MAX_WIDTH)) begin
			eff_width = EW'(MAX_WIDTH);
		end else begin
			eff_width = EW'(row_width_q);
		end
	end

	assign copies_m1 = CNT_W'(eff_scale - ES'(1));

	// Row position and the count of repeated rows still owed by the host.
	logic [COL_W-1:0] col_q;
	logic [CNT_W-1:0] replays_q;

	// Stage 1 is the copy emitter: it holds one item and counts its copies.
	logic              valid_s1;
	logic [CNT_W-1:0]  ncopy_s1;
	logic [CNT_W-1:0]  copy_s1;
	logic              row_done_s1;
	logic              use_ram_s1;
	logic [1:0]        status_s1;
	logic [pru_pkg::PIX_W-1:0] pix_s1;

	// Stage 2 is the output register.
	logic              valid_s2;
	pru_pkg::pix_out_t data_s2;

	logic                      accept;
	logic                      row_done;
	logic                      is_replay;
	logic                      item_err;
	logic [1:0]                item_status;
	logic [pru_pkg::PIX_W-1:0] in_pix;
	logic                      s2_load;
	logic                      fin_copy;
	logic                      s1_done;
	logic                      ram_wr;
	logic                      ram_rd;
	logic [pru_pkg::PIX_W-1:0] ram_q;
	logic [pru_pkg::PIX_W-1:0] copy_pix;

	assign s2_load  = !valid_s2 || !up_stall;
	assign fin_copy = (copy_s1 == ncopy_s1);
	assign s1_done  = valid_s1 && s2_load && fin_copy;

	// A new item enters when the emitter is empty, or in the cycle in which it
	// hands its final copy to the output register. A stalled output register
	// holds the emitter, and a busy emitter holds the input.
	assign pix_stall = valid_s1 && !s1_done;
	assign accept    = pix_valid && !pix_stall;

	assign is_replay = (pix_data.func == pru_pkg::FUNC_REPLAY);
	assign row_done  = ((EW'(col_q) + EW'(1)) >= eff_width);
	assign in_pix    = {pix_data.red_in, pix_data.green_in, pix_data.blue_in};

	// A replay with no repeated row due, or a pixel while repeated rows are
	// still due, is refused with a single error result.
	always_comb begin
		item_err    = 1'b0;
		item_status = pru_pkg::STATUS_OK;
		if (is_replay && (replays_q == '0)) begin
			item_err    = 1'b1;
			item_status = pru_pkg::STATUS_NO_REPLAY;
		end else if (!is_replay && (replays_q != '0)) begin
			item_err    = 1'b1;
			item_status = pru_pkg::STATUS_REPLAY_DUE;
		end
	end

	// Pixels write the line store and replays read it, both at the transfer
	// edge. A replay can only be accepted in a later transfer than the pixel
	// that wrote its entry, so the read always sees the written data.
	assign ram_wr = accept && !is_replay && !item_err;
	assign ram_rd = accept && is_replay && !item_err;

	pru_ram #(
		.DATA_W (pru_pkg::PIX_W),
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_line_store (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (col_q),
		.wr_data (in_pix),
		.rd_en   (ram_rd),
		.rd_addr (col_q),
		.rd_data (ram_q)
	);

	// Row state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			replays_q <= '0;
		end else if (accept && !item_err) begin
			if (row_done) begin
				col_q <= '0;
				if (is_replay) begin
					replays_q <= replays_q - CNT_W'(1);
				end else begin
					replays_q <= copies_m1;
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Emitter control. The read data stays in the RAM output register while
	// the item is held, since no other read is issued until it leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			copy_s1  <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			copy_s1  <= '0;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end else if (valid_s1 && s2_load) begin
			copy_s1 <= copy_s1 + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ncopy_s1    <= item_err ? '0 : copies_m1;
			row_done_s1 <= row_done && !item_err;
			use_ram_s1  <= is_replay && !item_err;
			status_s1   <= item_status;
			pix_s1      <= item_err ? '0 : in_pix;
		end
	end

	assign copy_pix = use_ram_s1 ? ram_q : pix_s1;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			data_s2.red_out   <= copy_pix[23:16];
			data_s2.green_out <= copy_pix[15:8];
			data_s2.blue_out  <= copy_pix[7:0];
			data_s2.row_end   <= fin_copy && row_done_s1;
			data_s2.last      <= fin_copy;
			data_s2.status    <= status_s1;
		end
	end

	assign up_valid = valid_s2;
	assign up_data  = data_s2;

endmodule

// File: dv/upscale_checker.sv
// ----------------------------------------------------------------------------
// upscale_checker
// Watches the register, source and result channels of the upscaler. It keeps
// its own copy of the row state, predicts the copies that each source transfer
// must produce and compares every result transfer against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module upscale_checker #(
	parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
	parameter int MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           pix_valid,
	input  logic                           pix_stall,
	input  pru_pkg::pix_in_t               pix_data,
	input  logic                           up_valid,
	input  logic                           up_stall,
	input  pru_pkg::pix_out_t              up_data,
	output int                             mismatch_count,
	output int                             outstanding,
	output int                             rows_owed,
	output int                             position,
	output int                             checked_count,
	output int                             error_count
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int OWED_W = $clog2(MAX_SCALE);

	logic [pru_pkg::PIX_W-1:0]   line_copy [MAX_WIDTH];
	logic [pru_pkg::SCALE_W-1:0] scale_reg;
	logic [pru_pkg::ROW_W-1:0]   width_reg;
	logic [COL_W-1:0]            col;
	logic [OWED_W-1:0]           owed;
	pru_pkg::pix_out_t           expected_copies [$];

	// Works out the results of one source transfer and advances the row state.
	function automatic void predict_copies(input pru_pkg::pix_in_t item);
		int unsigned               copies;
		int unsigned               span;
		logic                      row_done;
		logic [pru_pkg::PIX_W-1:0] rgb;
		pru_pkg::pix_out_t         copy;
		copies = (scale_reg == 0) ? 1 : (scale_reg > MAX_SCALE) ? MAX_SCALE : scale_reg;
		span = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		row_done = (int'(col) + 1 >= span);
		copy = '0;
		// A pixel while rows are owed, or a replay with none owed, is refused.
		if ((item.func == pru_pkg::FUNC_PIXEL) == (owed != 0)) begin
			copy.last = 1'b1;
			copy.status = (item.func == pru_pkg::FUNC_PIXEL) ?
				pru_pkg::STATUS_REPLAY_DUE : pru_pkg::STATUS_NO_REPLAY;
			expected_copies.push_back(copy);
			return;
		end
		if (item.func == pru_pkg::FUNC_PIXEL) begin
			rgb = {item.red_in, item.green_in, item.blue_in};
			line_copy[col] = rgb;
		end else begin
			rgb = line_copy[col];
		end
		for (int unsigned k = 0; k < copies; k++) begin
			copy.red_out = rgb[23:16];
			copy.green_out = rgb[15:8];
			copy.blue_out = rgb[7:0];
			copy.last = (k + 1 == copies);
			copy.row_end = copy.last && row_done;
			copy.status = pru_pkg::STATUS_OK;
			expected_copies.push_back(copy);
		end
		if (row_done) begin
			col = '0;
			owed = (item.func == pru_pkg::FUNC_PIXEL) ? OWED_W'(copies - 1) : owed - 1'b1;
		end else begin
			col = col + 1'b1;
		end
	endfunction

	function automatic void compare_copy(input pru_pkg::pix_out_t got);
		pru_pkg::pix_out_t want;
		if (expected_copies.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			mismatch_count++;
			return;
		end
		want = expected_copies.pop_front();
		checked_count++;
		if (want.status != pru_pkg::STATUS_OK)
			error_count++;
		if (got !== want) begin
			if (got.red_out !== want.red_out)
				$display("%0t: red_out expected %h actual %h", $time, want.red_out, got.red_out);
			if (got.green_out !== want.green_out)
				$display("%0t: green_out expected %h actual %h", $time, want.green_out,
					got.green_out);
			if (got.blue_out !== want.blue_out)
				$display("%0t: blue_out expected %h actual %h", $time, want.blue_out,
					got.blue_out);
			if (got.row_end !== want.row_end)
				$display("%0t: row_end expected %b actual %b", $time, want.row_end, got.row_end);
			if (got.last !== want.last)
				$display("%0t: last expected %b actual %b", $time, want.last, got.last);
			if (got.status !== want.status)
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_reg = pru_pkg::SCALE_W'(1);
			width_reg = pru_pkg::ROW_W'(1);
			col = '0;
			owed = '0;
			expected_copies.delete();
			mismatch_count = 0;
			checked_count = 0;
			error_count = 0;
		end else begin
			// Results are checked before the new source transfer is predicted, so a
			// stray result can never match copies queued at the same edge.
			if (up_valid && !up_stall)
				compare_copy(up_data);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == pru_pkg::REG_SCALE_FACTOR)
					scale_reg = cfg_data[pru_pkg::SCALE_W-1:0];
				else if (cfg_index == pru_pkg::REG_ROW_WIDTH)
					width_reg = cfg_data[pru_pkg::ROW_W-1:0];
			end
			if (pix_valid && !pix_stall)
				predict_copies(pix_data);
		end
		outstanding = expected_copies.size();
		rows_owed = owed;
		position = col;
	end

endmodule

// File: dv/tb_pixel_replicating_upscaler.sv
// ----------------------------------------------------------------------------
// tb_pixel_replicating_upscaler
// Drives source pixels, replays and register writes into the upscaler, with
// random idling on the source side and random stalls on the result side.
// A checker beside the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pixel_replicating_upscaler;

	localparam int CLK_HALF = 4;
	// Quiet pauses before any register write and before the verdict; both are
	// ample for the pipeline to empty.
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	// Longest quiet stretch in a correct run is a streak of random stalls or
	// the settle pause, far below this.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_ITEMS = 35;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pru_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           pix_valid;
	logic                           pix_stall;
	pru_pkg::pix_in_t               pix_data;
	logic                           up_valid;
	logic                           up_stall = 1'b0;
	pru_pkg::pix_out_t              up_data;

	int mismatch_count;
	int outstanding;
	int rows_owed;
	int position;
	int checked_count;
	int error_count;

	// Percent of cycles in which the source holds back and the sink stalls.
	int src_idle_pct = 26;
	int sink_stall_pct = 61;
	int items_sent = 0;
	int reg_writes = 0;
	int quiet_cycles = 0;

	always #CLK_HALF clk = ~clk;

	pixel_replicating_upscaler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.up_valid  (up_valid),
		.up_stall  (up_stall),
		.up_data   (up_data)
	);

	upscale_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pix_valid      (pix_valid),
		.pix_stall      (pix_stall),
		.pix_data       (pix_data),
		.up_valid       (up_valid),
		.up_stall       (up_stall),
		.up_data        (up_data),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding),
		.rows_owed      (rows_owed),
		.position       (position),
		.checked_count  (checked_count),
		.error_count    (error_count)
	);

	// The sink decides afresh at every falling edge whether to stall, so stalls
	// land on every phase of a copy burst.
	always @(negedge clk) begin
		up_stall <= arst_n && ($urandom_range(0, 99) < sink_stall_pct);
	end

	// Watchdog: any cycle with a transfer on any channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && !pix_stall) || (up_valid && !up_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired with %0d results outstanding", $time,
					outstanding);
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic pru_pkg::pix_in_t make_item(input logic func, input logic [23:0] rgb);
		pru_pkg::pix_in_t item;
		item.func = func;
		{item.red_in, item.green_in, item.blue_in} = rgb;
		return item;
	endfunction

	// Presents one source item, with random idle cycles ahead of it, and
	// returns at the falling edge after its transfer. Valid is left high so
	// that back-to-back items never lower and raise it in the same step.
	task automatic push_source(input pru_pkg::pix_in_t item);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		pix_data <= item;
		do @(posedge clk); while (pix_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input logic [pru_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[pru_pkg::CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		reg_writes++;
	endtask

	// Registers change only with the block idle: the source is lowered, every
	// predicted copy must have arrived, and a short pause covers the pipeline.
	// Callers only come here with no replayed rows owed, so a replay can never
	// read a line buffer entry that was not written in the current row.
	task automatic configure(input int scale_val, input int width_val);
		pix_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(pru_pkg::REG_SCALE_FACTOR, scale_val);
		write_reg(pru_pkg::REG_ROW_WIDTH, width_val);
		cfg_valid <= 1'b0;
	endtask

	// Sends the item that the row protocol calls for next, with random color.
	// Now and then a wrong-kind item goes ahead of it; the block must refuse
	// that one without disturbing the row.
	task automatic send_step();
		if ($urandom_range(0, 7) == 0)
			push_source(make_item(rows_owed != 0 ? pru_pkg::FUNC_PIXEL : pru_pkg::FUNC_REPLAY,
				24'($urandom())));
		push_source(make_item(rows_owed != 0 ? pru_pkg::FUNC_REPLAY : pru_pkg::FUNC_PIXEL,
			24'($urandom())));
	endtask

	task automatic run_directed();
		// Reset settings (scale 1, width 1): color extremes, then a replay with
		// nothing owed.
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'h000000));
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'hFFFFFF));
		push_source(make_item(pru_pkg::FUNC_REPLAY, 24'hFFFFFF));
		// A 2x2 frame with a premature replay and a pixel while a row is owed.
		configure(2, 2);
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'hAA55AA));
		push_source(make_item(pru_pkg::FUNC_REPLAY, 24'h123456));
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'h55AA55));
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'h0F0F0F));
		push_source(make_item(pru_pkg::FUNC_REPLAY, 24'h000000));
		push_source(make_item(pru_pkg::FUNC_REPLAY, 24'hFFFFFF));
		// Zero in both registers behaves as one.
		configure(0, 0);
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'h800001));
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'h7FFFFE));
		// Oversized width is clamped; three pixels in, the width shrinks below
		// the current position, so the next pixel closes the row.
		configure(3, 8191);
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'h010203));
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'hFEFDFC));
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'h336699));
		configure(3, 2);
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'hC0FFEE));
		repeat (4) push_source(make_item(pru_pkg::FUNC_REPLAY, 24'h000000));
		// Oversized scale acts as the maximum, then the maximum itself, both in
		// the middle of a maximum-width row; a shrink to one closes the row.
		configure(127, 4096);
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'hFF00FF));
		configure(64, 4096);
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'h00FF00));
		configure(2, 1);
		push_source(make_item(pru_pkg::FUNC_PIXEL, 24'h5A5A5A));
		push_source(make_item(pru_pkg::FUNC_REPLAY, 24'hA5A5A5));
	endtask

	// Mostly whole frames (source row plus its replays) under a fresh random
	// setting; otherwise a short run that may leave a row half done, so the
	// next setting lands mid-row. A frame that outlasts the budget is carried
	// on by the next phase.
	task automatic random_phase(input int budget);
		int stop_at;
		int pick;
		int scale_val;
		int width_val;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			if (rows_owed == 0) begin
				pick = $urandom_range(0, 19);
				if (pick < 16)
					scale_val = $urandom_range(1, 4);
				else if (pick == 16)
					scale_val = 0;
				else if (pick == 17)
					scale_val = 64;
				else if (pick == 18)
					scale_val = 127;
				else
					scale_val = $urandom_range(5, 16);
				// Large scales get one-pixel rows to keep frames short.
				if (pick >= 17)
					width_val = $urandom_range(0, 1);
				else if ($urandom_range(0, 15) == 0)
					width_val = 0;
				else
					width_val = $urandom_range(1, 6);
				configure(scale_val, width_val);
			end
			if ($urandom_range(0, 9) < 7) begin
				repeat ($urandom_range(1, 2)) begin
					do begin
						send_step();
					end while ((position != 0 || rows_owed != 0) && items_sent < stop_at);
				end
			end else begin
				repeat ($urandom_range(1, 3)) send_step();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = pru_pkg::REG_SCALE_FACTOR;
		cfg_data = '0;
		pix_valid = 1'b0;
		pix_data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Phase one: source idles lightly, sink stalls heavily.
		run_directed();
		random_phase(PHASE_ITEMS);
		// Phase two: the other way round.
		src_idle_pct = 61;
		sink_stall_pct = 26;
		random_phase(PHASE_ITEMS);
		// Phase three: full rate on both sides.
		src_idle_pct = 0;
		sink_stall_pct = 0;
		random_phase(PHASE_ITEMS);

		// Drain: every predicted copy must arrive, then a quiet pause catches
		// anything extra.
		pix_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run covered %0d source transfers and %0d register writes; %0d results checked,",
			items_sent, reg_writes, checked_count);
		$display("%0d of them refusals, over scales up to the clamp and widths up to 8191.",
			error_count);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d result transfers were wrong or unexpected", mismatch_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/pru_pkg.sv
hdl/pru_ram.sv
hdl/pixel_replicating_upscaler.sv
dv/upscale_checker.sv
dv/tb_pixel_replicating_upscaler.sv
